// ===== rtl/rpc_pkg.sv =====
// Shared widths, stage payload types and helper functions for the point rotator.
// Depends on nothing; imported by rotate_point_about_center.
package rpc_pkg;

  // Field widths and stage count.
  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int ROTATION_STAGES = 16;

  // Fixed-point formats inside the rotator.
  localparam int GUARD_BITS  = 16;
  localparam int GAIN_FRAC   = 30;
  localparam int PRE_SHIFT   = GAIN_FRAC - GUARD_BITS;
  localparam int GAIN_W      = 31;
  localparam logic signed [GAIN_W-1:0] INV_GAIN = GAIN_W'(652032874);
  localparam int ATAN_ENTRIES = 24;
  localparam int TURN_BITS   = 32;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = DIFF_W + GAIN_W;
  // Offset after gain scaling plus two bits of CORDIC growth.
  localparam int DW     = PROD_W - PRE_SHIFT + 2;
  localparam int ZW     = TURN_BITS + 2;
  localparam int RW     = DW - GUARD_BITS;
  localparam int SUM_W  = RW + 1;
  localparam int ZSHIFT = TURN_BITS - ANGLE_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    angle_t                   ang;
    coord_t                   cx;
    coord_t                   cy;
  } diff_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic                     fold;
    angle_t                   ang;
    coord_t                   cx;
    coord_t                   cy;
  } prod_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    coord_t               cx;
    coord_t               cy;
  } crd_t;

  typedef struct packed {
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
    coord_t               cx;
    coord_t               cy;
  } rnd_t;

  // atan(2^-idx) in units of 2^32 per full turn.
  function automatic logic signed [ZW-1:0] atan_lut(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = ZW'(536870912);
      1:       val = ZW'(316933406);
      2:       val = ZW'(167458907);
      3:       val = ZW'(85004756);
      4:       val = ZW'(42667331);
      5:       val = ZW'(21354465);
      6:       val = ZW'(10679838);
      7:       val = ZW'(5340410);
      8:       val = ZW'(2670357);
      9:       val = ZW'(1335087);
      10:      val = ZW'(667544);
      11:      val = ZW'(333772);
      12:      val = ZW'(166886);
      13:      val = ZW'(83443);
      14:      val = ZW'(41722);
      15:      val = ZW'(20861);
      16:      val = ZW'(10430);
      17:      val = ZW'(5215);
      18:      val = ZW'(2608);
      19:      val = ZW'(1304);
      20:      val = ZW'(652);
      21:      val = ZW'(326);
      22:      val = ZW'(163);
      23:      val = ZW'(81);
      default: val = '0;
    endcase
    return val;
  endfunction

  // Clamp a sum to the signed coordinate range.
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] s);
    logic   all_same;
    coord_t res;
    all_same = (s[SUM_W-1:COORD_WIDTH-1] == '0) || (s[SUM_W-1:COORD_WIDTH-1] == '1);
    if (all_same) begin
      res = s[COORD_WIDTH-1:0];
    end else if (s[SUM_W-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== rtl/rotate_point_about_center.sv =====
// Pipelined CORDIC rotation of a point about a center, with rounding and saturation.
// Depends on rpc_pkg for widths, stage types, the arctangent table and saturation.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | sink      | in_valid/in_stall  | point_x/y, rotation_angle, center_x/y
//   out     | source    | out_valid/out_stall| rotated_x, rotated_y
//
// One beat enters per cycle while in_stall is low; each beat passes the diff, product,
// CORDIC load, one register stage per CORDIC iteration, round and output registers.
// rst_n (synchronous, active low) clears the valid bits only; payload is not reset.
// Every stage holds its beat while the stage after it is full and blocked, so
// empty stages keep filling under an output stall; in_stall rises only once the
// whole pipe is full.
module rotate_point_about_center
  import rpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  coord_t in_point_x,
  input  coord_t in_point_y,
  input  angle_t in_rotation_angle,
  input  coord_t in_center_x,
  input  coord_t in_center_y,
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t out_rotated_x,
  output coord_t out_rotated_y
);

  localparam int N = ROTATION_STAGES;

  // Stage registers: diff, product, CORDIC chain (index 0 is the loaded offset), round, output.
  diff_t  d_r;
  logic   d_v_r;
  prod_t  p_r;
  logic   p_v_r;
  crd_t   c_r   [0:N];
  logic   c_v_r [0:N];
  rnd_t   r_r;
  logic   r_v_r;
  coord_t ox_r;
  coord_t oy_r;
  logic   o_v_r;

  // Load enables: a stage loads when it is empty or its beat moves on.
  logic d_en;
  logic p_en;
  logic c_en [0:N];
  logic r_en;
  logic o_en;

  assign o_en = !o_v_r || !out_stall;
  assign r_en = !r_v_r || o_en;
  assign c_en[N] = !c_v_r[N] || r_en;
  assign p_en = !p_v_r || c_en[0];
  assign d_en = !d_v_r || p_en;

  assign in_stall      = !d_en;
  assign out_valid     = o_v_r;
  assign out_rotated_x = ox_r;
  assign out_rotated_y = oy_r;

  // Next values per stage.
  diff_t d_nxt;
  prod_t p_nxt;
  crd_t  c0_nxt;
  rnd_t  r_nxt;
  coord_t ox_nxt;
  coord_t oy_nxt;

  // Offset from the center.
  always_comb begin
    d_nxt.dx  = DIFF_W'(in_point_x) - DIFF_W'(in_center_x);
    d_nxt.dy  = DIFF_W'(in_point_y) - DIFF_W'(in_center_y);
    d_nxt.ang = in_rotation_angle;
    d_nxt.cx  = in_center_x;
    d_nxt.cy  = in_center_y;
  end

  // Scale by the inverse CORDIC gain; fold wide angles by a half turn.
  // Adding a half turn and subtracting one agree modulo a full turn: flip the top bit.
  always_comb begin
    logic [1:0] top;
    top        = d_r.ang[ANGLE_WIDTH-1 -: 2];
    p_nxt.px   = PROD_W'(d_r.dx) * PROD_W'(INV_GAIN);
    p_nxt.py   = PROD_W'(d_r.dy) * PROD_W'(INV_GAIN);
    // At or above a quarter turn (01) or below minus a quarter turn (10).
    p_nxt.fold = top[1] ^ top[0];
    p_nxt.ang  = p_nxt.fold ? {~d_r.ang[ANGLE_WIDTH-1], d_r.ang[ANGLE_WIDTH-2:0]} : d_r.ang;
    p_nxt.cx   = d_r.cx;
    p_nxt.cy   = d_r.cy;
  end

  // Drop to guard-bit precision (floor), negate on fold, widen the angle to turn units.
  always_comb begin
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [ZW-1:0] za;
    sx        = DW'(p_r.px >>> PRE_SHIFT);
    sy        = DW'(p_r.py >>> PRE_SHIFT);
    za        = ZW'(p_r.ang);
    c0_nxt.x  = p_r.fold ? -sx : sx;
    c0_nxt.y  = p_r.fold ? -sy : sy;
    c0_nxt.z  = za <<< ZSHIFT;
    c0_nxt.cx = p_r.cx;
    c0_nxt.cy = p_r.cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      p_v_r <= 1'b0;
    end else begin
      if (d_en) begin
        d_v_r <= in_valid;
      end
      if (p_en) begin
        p_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_r <= d_nxt;
    end
    if (p_en) begin
      p_r <= p_nxt;
    end
    if (c_en[0]) begin
      c_r[0] <= c0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r[0] <= 1'b0;
    end else if (c_en[0]) begin
      c_v_r[0] <= p_v_r;
    end
  end

  // One CORDIC micro-rotation per stage, shift fixed by the stage index.
  for (genvar k = 0; k < N; k++) begin : g_crd
    crd_t c_nxt;

    assign c_en[k] = !c_v_r[k] || c_en[k+1];

    always_comb begin
      logic signed [DW-1:0] xs;
      logic signed [DW-1:0] ys;
      logic signed [ZW-1:0] at;
      xs       = c_r[k].x >>> k;
      ys       = c_r[k].y >>> k;
      at       = atan_lut(k);
      c_nxt.cx = c_r[k].cx;
      c_nxt.cy = c_r[k].cy;
      if (!c_r[k].z[ZW-1]) begin
        c_nxt.x = c_r[k].x - ys;
        c_nxt.y = c_r[k].y + xs;
        c_nxt.z = c_r[k].z - at;
      end else begin
        c_nxt.x = c_r[k].x + ys;
        c_nxt.y = c_r[k].y - xs;
        c_nxt.z = c_r[k].z + at;
      end
    end

    always_ff @(posedge clk) begin
      if (c_en[k+1]) begin
        c_r[k+1] <= c_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[k+1] <= 1'b0;
      end else if (c_en[k+1]) begin
        c_v_r[k+1] <= c_v_r[k];
      end
    end
  end

  // Round half up to whole coordinate units, dropping the guard bits.
  localparam logic signed [DW-1:0] ROUND_HALF = DW'(1) <<< (GUARD_BITS - 1);

  always_comb begin
    r_nxt.rx = RW'((c_r[N].x + ROUND_HALF) >>> GUARD_BITS);
    r_nxt.ry = RW'((c_r[N].y + ROUND_HALF) >>> GUARD_BITS);
    r_nxt.cx = c_r[N].cx;
    r_nxt.cy = c_r[N].cy;
  end

  // Add the center back and clamp.
  always_comb begin
    ox_nxt = sat_coord(SUM_W'(r_r.rx) + SUM_W'(r_r.cx));
    oy_nxt = sat_coord(SUM_W'(r_r.ry) + SUM_W'(r_r.cy));
  end

  always_ff @(posedge clk) begin
    if (r_en) begin
      r_r <= r_nxt;
    end
    if (o_en) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (r_en) begin
        r_v_r <= c_v_r[N];
      end
      if (o_en) begin
        o_v_r <= r_v_r;
      end
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench for rotate_point_about_center: directed table plus random streams, self-checked
// against an in-bench fixed-point CORDIC predictor. Depends on rpc_pkg and the top-level RTL.
module tb
  import rpc_pkg::*;
();

  // One expected or observed result beat.
  typedef struct packed {
    coord_t x;
    coord_t y;
  } rotated_t;

  // One row of stimulus; when pinned is set, the typed-in result is the expectation.
  typedef struct packed {
    coord_t px;
    coord_t py;
    angle_t ang;
    coord_t cx;
    coord_t cy;
    logic   pinned;
    coord_t ex;
    coord_t ey;
  } point_row_t;

  localparam coord_t CMIN    = 16'sh8000;
  localparam coord_t CMAX    = 16'sh7FFF;
  localparam angle_t ANG_MIN = 16'sh8000;
  localparam angle_t ANG_MAX = 16'sh7FFF;
  localparam angle_t ANG_QTR = 16'sh4000;
  localparam int     N_DIRECTED = 22;
  localparam int     N_RANDOM   = 1500;

  // Reciprocal CORDIC gain in Q30 and arctangent steps, 2^32 per full turn.
  localparam longint GAIN_RECIP_Q30 = 64'sd652032874;
  localparam longint ATAN_STEP [ATAN_ENTRIES] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340410,
    64'sd2670357,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  angle_t in_rotation_angle = '0;
  coord_t in_center_x = '0;
  coord_t in_center_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_rotated_x;
  coord_t out_rotated_y;

  rotated_t   rotated_q [$];
  point_row_t directed_rows [N_DIRECTED];
  bit         calm = 1'b0;   // set: neither side idles
  int         err_count = 0;
  int         beats_sent = 0;
  int         beats_checked = 0;
  int         saturated_seen = 0;

  rotate_point_about_center DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_rotation_angle (in_rotation_angle),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rotated_x     (out_rotated_x),
    .out_rotated_y     (out_rotated_y)
  );

  always #5 clk = ~clk;

  // Round half up off the guard bits, add the center back, clamp to the coordinate range.
  function automatic coord_t round_and_clamp(input longint acc, input coord_t ctr);
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -(longint'(1) <<< (COORD_WIDTH - 1));
    r = ((acc + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS) + longint'(ctr);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return coord_t'(r);
  endfunction

  // Rotate (p - c) by the binary angle with a gain-compensated CORDIC, then add c back.
  function automatic rotated_t rotate_about(input point_row_t row);
    longint   x;
    longint   y;
    longint   z;
    longint   a;
    longint   xs;
    longint   ys;
    longint   quarter;
    longint   half;
    rotated_t res;
    quarter = longint'(1) <<< (ANGLE_WIDTH - 2);
    half    = longint'(1) <<< (ANGLE_WIDTH - 1);
    x = ((longint'(row.px) - longint'(row.cx)) * GAIN_RECIP_Q30) >>> (30 - GUARD_BITS);
    y = ((longint'(row.py) - longint'(row.cy)) * GAIN_RECIP_Q30) >>> (30 - GUARD_BITS);
    a = longint'(row.ang);
    // Fold wide angles into the CORDIC range with a half-turn flip.
    if (a >= quarter) begin
      a = a - half;
      x = -x;
      y = -y;
    end else if (a < -quarter) begin
      a = a + half;
      x = -x;
      y = -y;
    end
    z = a <<< (32 - ANGLE_WIDTH);
    for (int i = 0; i < ROTATION_STAGES && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end
    end
    res.x = round_and_clamp(x, row.cx);
    res.y = round_and_clamp(y, row.cy);
    return res;
  endfunction

  // Pick a random coordinate that lands on the range ends often.
  function automatic coord_t pick_coord(input bit edgy);
    int sel;
    sel = $urandom_range(0, 3);
    if (!edgy || sel == 3) return coord_t'($urandom);
    if (sel == 0) return CMIN;
    if (sel == 1) return CMAX;
    return '0;
  endfunction

  // Build one random item, weighted toward small offsets, fold boundaries and range ends.
  function automatic point_row_t random_point();
    point_row_t row;
    int         kind;
    int         k;
    kind = $urandom_range(0, 99);
    row = '0;
    row.ang = angle_t'($urandom);
    row.cx  = coord_t'($urandom);
    row.cy  = coord_t'($urandom);
    row.px  = coord_t'($urandom);
    row.py  = coord_t'($urandom);
    if (kind >= 50 && kind < 70) begin
      // Point close to the center: small offsets, exercise rounding.
      row.px = row.cx + coord_t'($urandom_range(0, 64)) - 16'sd32;
      row.py = row.cy + coord_t'($urandom_range(0, 64)) - 16'sd32;
    end else if (kind >= 70 && kind < 85) begin
      // Angle on or next to the quarter- and half-turn folds, or at or next to zero.
      k = $urandom_range(0, 8);
      case (k)
        0:       row.ang = ANG_QTR;
        1:       row.ang = ANG_QTR - 16'sd1;
        2:       row.ang = -ANG_QTR;
        3:       row.ang = -ANG_QTR - 16'sd1;
        4:       row.ang = ANG_MIN;
        5:       row.ang = ANG_MAX;
        6:       row.ang = 16'sd1;
        7:       row.ang = -16'sd1;
        default: row.ang = '0;
      endcase
    end else if (kind >= 85) begin
      // Coordinates at the range ends: drive saturation both ways.
      row.px = pick_coord(1'b1);
      row.py = pick_coord(1'b1);
      row.cx = pick_coord(1'b1);
      row.cy = pick_coord(1'b1);
    end
    return row;
  endfunction

  // Present one beat, hold it until accepted, then queue what it should produce.
  task automatic apply_point(input point_row_t row);
    rotated_t want;
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 37);
    end
    in_valid          <= 1'b1;
    in_point_x        <= row.px;
    in_point_y        <= row.py;
    in_rotation_angle <= row.ang;
    in_center_x       <= row.cx;
    in_center_y       <= row.cy;
    do @(posedge clk); while (in_stall);
    if (row.pinned) begin
      want.x = row.ex;
      want.y = row.ey;
    end else begin
      want = rotate_about(row);
    end
    rotated_q.push_back(want);
    beats_sent++;
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // Receiver backpressure: stall with a chance of about 37 in 100 each clock, none during the calm stretch.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 37);
  end

  // Compare every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d", $time, out_rotated_x, out_rotated_y);
        err_count++;
      end else begin
        want = rotated_q.pop_front();
        beats_checked++;
        if (out_rotated_x != want.x) begin
          $display("%0t: rotated_x expected %0d actual %0d", $time, want.x, out_rotated_x);
          err_count++;
        end
        if (out_rotated_y != want.y) begin
          $display("%0t: rotated_y expected %0d actual %0d", $time, want.y, out_rotated_y);
          err_count++;
        end
        if (want.x == CMAX || want.x == CMIN || want.y == CMAX || want.y == CMIN)
          saturated_seen++;
      end
    end
  end

  initial begin
    // Directed rows: px, py, angle, cx, cy, pinned, expected x, expected y.
    // Pinned rows: zero offset returns the center for any angle; a half-turn flip of
    // a full-range offset saturates each axis to the end it points at.
    directed_rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{16'sd1000, -16'sd2000, 16'sd12345, 16'sd1000, -16'sd2000, 1'b1,
        16'sd1000, -16'sd2000},
      '{CMAX, CMAX, ANG_MIN, CMAX, CMAX, 1'b1, CMAX, CMAX},
      '{CMIN, CMIN, ANG_MAX, CMIN, CMIN, 1'b1, CMIN, CMIN},
      '{CMIN, CMIN, ANG_MIN, CMAX, CMAX, 1'b1, CMAX, CMAX},
      '{CMAX, CMAX, ANG_MIN, CMIN, CMIN, 1'b1, CMIN, CMIN},
      '{CMIN, CMAX, ANG_MIN, CMAX, CMIN, 1'b1, CMAX, CMIN},
      // Fold boundaries on both sides of plus and minus a quarter turn.
      '{16'sd1600, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, 16'sd0, ANG_QTR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, 16'sd0, 16'sd16383, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, 16'sd0, -16'sd16385, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, -16'sd800, ANG_MAX, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, -16'sd800, ANG_MIN, 16'sd16, -16'sd16, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1600, 16'sd1600, 16'sd8192, -16'sd320, 16'sd480, 1'b0, 16'sd0, 16'sd0},
      // Range ends of the point with a zero center.
      '{CMAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{CMIN, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd0, CMAX, ANG_QTR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{CMAX, CMIN, 16'sd8192, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      // Tiny offsets and angles for rounding near zero, then a large offset about an off-origin center.
      '{-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, ANG_QTR, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{-16'sd20000, 16'sd15000, -16'sd8192, 16'sd10000, -16'sd12000, 1'b0,
        16'sd0, 16'sd0}
    };

    // Hold reset low, then release it on a rising edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) apply_point(directed_rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Let the pipe run dry now and then so the sender restarts from empty.
      if (n == 300 || n == 1200) wait_drained();
      // Run a long stretch with no idling on either side to fill the pipe.
      calm = (n >= 600 && n < 900);
      apply_point(random_point());
    end

    wait_drained();
    repeat (ROTATION_STAGES + 10) @(posedge clk);

    $display("Sent %0d beats (%0d directed), checked %0d results, %0d touched saturation.",
             beats_sent, N_DIRECTED, beats_checked, saturated_seen);
    $display("Covered fold boundaries, full-range offsets, near-center rounding and backpressure.");
    if (err_count == 0) begin
      $display("[rotate_point_about_center] OK");
    end else begin
      $display("[rotate_point_about_center] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Timeout with %0d results still outstanding", rotated_q.size());
    $display("[rotate_point_about_center] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rpc_pkg.sv
rtl/rotate_point_about_center.sv
test/tb.sv
